// ===== rtl/ula_pkg.sv =====
// ----------------------------------------------------------------------------
// ula_pkg
// Shared types and constants for the UART line assembler.
// ----------------------------------------------------------------------------
package ula_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int CHAR_W         = 8;
  localparam int LEN_W          = 7;   // msg_length / fill count / max_length width
  localparam int CMD_DEPTH      = 2;   // one line per store bank

  localparam logic [CHAR_W-1:0] CODE_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_BS   = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_BANG = 8'h21;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 7'd64;

  localparam int            PADDR_W       = 3;
  localparam logic          REG_BREAKOUT  = 1'b0;   // paddr[2] selects the register
  localparam logic          REG_MAXLEN    = 1'b1;

  // finished line handed from the front to the back
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } emit_cmd_t;

  // back tells the front that a bank has been fully read out
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_done_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD
  } back_state_t;

endpackage

// ===== rtl/ula_ram.sv =====
// ----------------------------------------------------------------------------
// ula_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ula_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ula_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ula_cmd_fifo
// Short queue of finished lines between the front and the back.
// ----------------------------------------------------------------------------
module ula_cmd_fifo
  import ula_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  emit_cmd_t push_cmd,
  input  logic      pop,
  output logic      not_empty,
  output emit_cmd_t head
);

  emit_cmd_t  slots [CMD_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      // depth never exceeds the bank count: front only pushes a free bank
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ula_front.sv =====
// ----------------------------------------------------------------------------
// ula_front
// Takes received characters, edits the current line and hands finished
// lines to the back. Two store banks: one is filled while the other drains.
// ----------------------------------------------------------------------------
module ula_front
  import ula_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  localparam int AW = $clog2(2 * LINE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] rx_char,
  input  logic [CHAR_W-1:0] breakout_code,
  input  logic [LEN_W-1:0]  max_length,
  input  bank_done_t        done,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [CHAR_W-1:0] ram_wdata,
  output logic              cmd_push,
  output emit_cmd_t         cmd
);

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LINE_DEPTH);

  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] fill_next;
  logic             bank;
  logic             bank_next;
  logic [1:0]       bank_busy;
  logic [LEN_W-1:0] lim;
  logic             accept;
  logic             term;
  logic             bksp;

  assign lim      = (max_length > DEPTH_L) ? DEPTH_L : max_length;
  assign s_tready = ~bank_busy[bank];
  assign accept   = s_tvalid & s_tready;
  assign term     = (rx_char == CODE_CR) || (rx_char == breakout_code) || (fill >= lim);
  assign bksp     = (rx_char == CODE_BS);

  assign cmd.bank  = bank;
  assign cmd.len   = fill;
  assign ram_wdata = rx_char;
  assign ram_waddr = bank ? (AW'(LINE_DEPTH) + AW'(fill)) : AW'(fill);

  always_comb begin
    fill_next = fill;
    bank_next = bank;
    ram_we    = 1'b0;
    cmd_push  = 1'b0;
    if (accept) begin
      priority if (term) begin
        fill_next = '0;
        if (fill != '0) begin
          cmd_push  = 1'b1;
          bank_next = ~bank;
        end
      end else if (bksp) begin
        if (fill != '0) begin
          fill_next = fill - LEN_W'(1);
        end
      end else begin
        // not terminating means fill < lim <= LINE_DEPTH, so there is room
        ram_we    = 1'b1;
        fill_next = fill + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bank      <= 1'b0;
      bank_busy <= 2'b00;
    end else begin
      fill <= fill_next;
      bank <= bank_next;
      if (cmd_push) begin
        bank_busy[bank] <= 1'b1;
      end
      if (done.valid) begin
        bank_busy[done.bank] <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/ula_back.sv =====
// ----------------------------------------------------------------------------
// ula_back
// Reads a finished line out of the store and sends it word by word
// through an output register.
// ----------------------------------------------------------------------------
module ula_back
  import ula_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  localparam int AW = $clog2(2 * LINE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_avail,
  input  emit_cmd_t         cmd_head,
  output logic              cmd_pop,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [CHAR_W-1:0] ram_rdata,
  output bank_done_t        done,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAR_W-1:0] msg_char,
  output logic              msg_last,
  output logic [LEN_W-1:0]  msg_length
);

  back_state_t      state;
  back_state_t      state_next;
  emit_cmd_t        cur;
  logic [LEN_W-1:0] k;
  logic             slot_free;
  logic             is_last;
  logic             load;

  assign slot_free = ~m_tvalid | m_tready;
  assign is_last   = ((k + LEN_W'(1)) == cur.len);
  assign ram_raddr = cur.bank ? (AW'(LINE_DEPTH) + AW'(k)) : AW'(k);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (cmd_avail) state_next = BK_READ;
      BK_READ: state_next = BK_LOAD;
      BK_LOAD: begin
        if (slot_free) begin
          state_next = is_last ? BK_IDLE : BK_READ;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    done.valid = 1'b0;
    done.bank  = cur.bank;
    unique case (state)
      BK_IDLE: cmd_pop = cmd_avail;
      BK_READ: ram_re  = 1'b1;
      BK_LOAD: begin
        load       = slot_free;
        done.valid = slot_free & is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_head;
    end
    if (load) begin
      msg_char   <= ram_rdata;
      msg_last   <= is_last;
      msg_length <= cur.len;
    end
    if (rst) begin
      state    <= BK_IDLE;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        k <= '0;
      end else if (load) begin
        k <= k + LEN_W'(1);
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/uart_line_assembler.sv =====
// ----------------------------------------------------------------------------
// uart_line_assembler
// Builds terminal lines from received characters with backspace editing
// and sends each finished line as a framed run of characters.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | content
//  s_*      | in  | s_tvalid / s_tready  | tdata[7:0] rx_char
//  m_*      | out | m_tvalid / m_tready  | tdata[7:0] msg_char, [14:8] msg_length;
//           |     |                      | tlast msg_last
//  apb      | in  | psel/penable, pready | 0x0 breakout_code, 0x4 max_length
//
// An input character is taken whenever s_tready is high. A finished line
// is read from the store one character at a time (RAM read, then output
// load) after the line is taken off the queue; the first word becomes valid
// after the line has passed the queue, a RAM read and the output load.
// The store has two banks: the front fills one while the back drains the
// other, so input stalls only when a second line ends before the first has
// drained. Reset is synchronous; no clearing pass, the store is only read
// below the fill count. Output stalls hold the output register.
// ----------------------------------------------------------------------------
module uart_line_assembler
  import ula_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,    // [7:0] rx_char
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,    // [7:0] msg_char, [14:8] msg_length, [15] zero
  output logic               m_tlast,    // msg_last
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(2 * LINE_DEPTH);

  logic [CHAR_W-1:0] breakout_code;
  logic [LEN_W-1:0]  max_length;
  logic              cfg_wr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic              cmd_push;
  emit_cmd_t         cmd;
  logic              cmd_pop;
  logic              cmd_avail;
  emit_cmd_t         cmd_head;
  bank_done_t        done;

  logic [CHAR_W-1:0] msg_char;
  logic [LEN_W-1:0]  msg_length;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      breakout_code <= CODE_BANG;
      max_length    <= MAX_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BREAKOUT: breakout_code <= pwdata[CHAR_W-1:0];
        REG_MAXLEN:   max_length    <= pwdata[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BREAKOUT: prdata = {{(32-CHAR_W){1'b0}}, breakout_code};
      REG_MAXLEN:   prdata = {{(32-LEN_W){1'b0}}, max_length};
      default:      prdata = '0;
    endcase
  end

  assign m_tdata = {1'b0, msg_length, msg_char};

  ula_front #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .rx_char       (s_tdata),
    .breakout_code (breakout_code),
    .max_length    (max_length),
    .done          (done),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .cmd_push      (cmd_push),
    .cmd           (cmd)
  );

  ula_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (cmd),
    .pop       (cmd_pop),
    .not_empty (cmd_avail),
    .head      (cmd_head)
  );

  ula_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(2 * LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ula_back #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_avail  (cmd_avail),
    .cmd_head   (cmd_head),
    .cmd_pop    (cmd_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .done       (done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .msg_char   (msg_char),
    .msg_last   (m_tlast),
    .msg_length (msg_length)
  );

endmodule
